/* rtl/lcts_pkg.sv */
// ----------------------------------------------------------------------------
// lcts_pkg
// shared types, register codes and reset values for the lba to chs splitter
// ----------------------------------------------------------------------------
package lcts_pkg;

  localparam int unsigned MAX_RUN_SECTORS = 64;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned GeoW   = 8;
  localparam int unsigned SbW    = 13;
  localparam int unsigned OffW   = 18;
  localparam int unsigned BytesW = 19;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [GeoW-1:0] SptReset   = 8'd18;
  localparam logic [GeoW-1:0] HeadsReset = 8'd2;
  localparam logic [SbW-1:0]  SbReset    = 13'd512;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPT    = 2'd0,
    CFG_HEADS  = 2'd1,
    CFG_SBYTES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_TRK,
    S_DIV_CYL,
    S_RUN
  } state_e;

  // divider status seen by the control side
  typedef struct packed {
    logic            done;
    logic [AddrW-1:0] quotient;
    logic [GeoW-1:0]  remainder;
  } div_stat_t;

  typedef struct packed {
    logic [AddrW-1:0]  cylinder;
    logic [GeoW-1:0]   head;
    logic [GeoW-1:0]   first_sector;
    logic [CountW-1:0] run_sectors;
    logic [OffW-1:0]   buffer_offset;
    logic [BytesW-1:0] run_bytes;
    logic              dir_out;
    logic              last_run;
  } run_t;

endpackage

/* rtl/lcts_req_if.sv */
// ----------------------------------------------------------------------------
// lcts_req_if
// request channel: start sector, sector count and direction
// ----------------------------------------------------------------------------
interface lcts_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_sector;
  logic [6:0]  sector_total;
  logic        write_dir;

  modport source (output valid, output start_sector, output sector_total,
                  output write_dir, input ready);
  modport sink   (input valid, input start_sector, input sector_total,
                  input write_dir, output ready);
endinterface

/* rtl/lcts_run_if.sv */
// ----------------------------------------------------------------------------
// lcts_run_if
// run channel: one word per track-bounded run
// ----------------------------------------------------------------------------
interface lcts_run_if;
  logic        valid;
  logic        ready;
  logic [15:0] cylinder;
  logic [7:0]  head;
  logic [7:0]  first_sector;
  logic [6:0]  run_sectors;
  logic [17:0] buffer_offset;
  logic [18:0] run_bytes;
  logic        dir_out;
  logic        last_run;

  modport source (output valid, output cylinder, output head, output first_sector,
                  output run_sectors, output buffer_offset, output run_bytes,
                  output dir_out, output last_run, input ready);
  modport sink   (input valid, input cylinder, input head, input first_sector,
                  input run_sectors, input buffer_offset, input run_bytes,
                  input dir_out, input last_run, output ready);
endinterface

/* rtl/lcts_div.sv */
// ----------------------------------------------------------------------------
// lcts_div
// bit-serial restoring divider, 16-bit dividend by 8-bit divisor, one
// quotient bit per cycle
// ----------------------------------------------------------------------------
module lcts_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lcts_pkg::AddrW-1:0] dividend_i,
  input  logic [lcts_pkg::GeoW-1:0]  divisor_i,
  output lcts_pkg::div_stat_t       stat_o
);
  import lcts_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [AddrW-1:0] dvd_q, dvd_d;
  logic [GeoW-1:0]  rem_q, rem_d;
  logic [GeoW-1:0]  div_q, div_d;
  logic [GeoW:0]    trial;
  logic             fits;

  assign trial = {rem_q, dvd_q[AddrW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // quotient bits shift in behind the dividend bits
      rem_d = fits ? GeoW'(trial - {1'b0, div_q}) : trial[GeoW-1:0];
      dvd_d = {dvd_q[AddrW-2:0], fits};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.done      = done_q;
  assign stat_o.quotient  = dvd_q;
  assign stat_o.remainder = rem_q;

endmodule

/* rtl/lba_to_chs_track_splitter_unit.sv */
// ----------------------------------------------------------------------------
// lba_to_chs_track_splitter_unit
// splits a linear sector request into runs that stay within one track
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | contents
//  req_i    | in  | valid/ready   | start_sector, sector_total, write_dir
//  run_o    | out | valid/ready   | cylinder, head, first_sector, run_sectors,
//           |     |               | buffer_offset, run_bytes, dir_out, last_run
//  cfg      | in  | write enable  | cfg_idx_i, cfg_data_i
//
//  first run word after a request is taken: two serial divides (by sectors
//  per track, then by heads), then a load; then one run word per
//  cycle unless run_o stalls; a run that carries the address past 65535 costs
//  two more divides; one request at a time: req_i.ready is high only when idle
//  the run word sits in an output register, stalls hold it; the next
//  request may be accepted while the last word waits
//  reset restores the default geometry and empties the output register
// ----------------------------------------------------------------------------
module lba_to_chs_track_splitter_unit #(
  parameter int unsigned MaxRunSectors = lcts_pkg::MAX_RUN_SECTORS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lcts_req_if.sink                    req_i,
  lcts_run_if.source                  run_o,
  input  logic                        cfg_we_i,
  input  logic [lcts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lcts_pkg::SbW-1:0]     cfg_data_i
);
  import lcts_pkg::*;

  localparam logic [CountW-1:0] MaxRun = CountW'(MaxRunSectors);

  logic [GeoW-1:0] spt_q, heads_q;
  logic [SbW-1:0]  sb_q;

  state_e state_q, state_d;

  logic [AddrW-1:0]  addr_q, addr_d;
  logic [CountW-1:0] left_q, left_d;
  logic              dir_q, dir_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [GeoW-1:0]   first_q, first_d;
  logic [GeoW-1:0]   head_q, head_d;
  logic [AddrW-1:0]  cyl_q, cyl_d;

  logic              vld_q, vld_d;
  run_t              out_q, out_d;

  logic [GeoW-1:0]   spt_eff, heads_eff;
  logic [GeoW-1:0]   room;
  logic [CountW-1:0] run_len, left_after, total_clamp;
  logic [SbW+CountW-1:0] prod;
  logic [AddrW:0]    addr_sum;
  logic [GeoW-1:0]   head_inc;
  logic              load, req_acc;

  logic              div_start;
  logic [AddrW-1:0]  div_dvd;
  logic [GeoW-1:0]   div_dvs;
  div_stat_t         div_st;

  lcts_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_st)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= SptReset;
      heads_q <= HeadsReset;
      sb_q    <= SbReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPT:    spt_q   <= cfg_data_i[GeoW-1:0];
        CFG_HEADS:  heads_q <= cfg_data_i[GeoW-1:0];
        CFG_SBYTES: sb_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign spt_eff   = (spt_q == '0) ? GeoW'(1) : spt_q;
  assign heads_eff = (heads_q == '0) ? GeoW'(1) : heads_q;

  assign total_clamp = (req_i.sector_total > MaxRun) ? MaxRun : req_i.sector_total;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // run arithmetic
  assign room       = spt_eff - first_q;
  assign run_len    = ({1'b0, left_q} > room) ? room[CountW-1:0] : left_q;
  assign left_after = left_q - run_len;
  assign prod       = run_len * sb_q;
  assign addr_sum   = {1'b0, addr_q} + {{(AddrW+1-CountW){1'b0}}, run_len};
  assign head_inc   = head_q + GeoW'(1);

  assign load = (state_q == S_RUN) && (!vld_q || run_o.ready);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    left_d    = left_q;
    dir_d     = dir_q;
    off_d     = off_q;
    first_d   = first_q;
    head_d    = head_q;
    cyl_d     = cyl_q;
    div_start = 1'b0;
    div_dvd   = req_i.start_sector;
    div_dvs   = spt_eff;
    vld_d     = vld_q && !run_o.ready;
    out_d     = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          addr_d = req_i.start_sector;
          left_d = total_clamp;
          dir_d  = req_i.write_dir;
          off_d  = '0;
          if (total_clamp != '0) begin
            div_start = 1'b1;
            state_d   = S_DIV_TRK;
          end
        end
      end
      S_DIV_TRK: begin
        if (div_st.done) begin
          first_d   = div_st.remainder;
          div_start = 1'b1;
          div_dvd   = div_st.quotient;
          div_dvs   = heads_eff;
          state_d   = S_DIV_CYL;
        end
      end
      S_DIV_CYL: begin
        if (div_st.done) begin
          cyl_d   = div_st.quotient;
          head_d  = div_st.remainder;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (load) begin
          vld_d               = 1'b1;
          out_d.cylinder      = cyl_q;
          out_d.head          = head_q;
          out_d.first_sector  = first_q;
          out_d.run_sectors   = run_len;
          out_d.buffer_offset = off_q;
          out_d.run_bytes     = BytesW'(prod);
          out_d.dir_out       = dir_q;
          out_d.last_run      = (left_after == '0);
          off_d  = off_q + OffW'(prod);
          left_d = left_after;
          addr_d = addr_sum[AddrW-1:0];
          if (left_after == '0) begin
            state_d = S_IDLE;
          end else if (addr_sum[AddrW]) begin
            // address wrapped: geometry no longer follows, divide again
            div_start = 1'b1;
            div_dvd   = addr_sum[AddrW-1:0];
            state_d   = S_DIV_TRK;
          end else begin
            // run ended on a track boundary, step to the next track
            first_d = '0;
            if (head_inc == heads_eff) begin
              head_d = '0;
              cyl_d  = cyl_q + AddrW'(1);
            end else begin
              head_d = head_inc;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    left_q  <= left_d;
    dir_q   <= dir_d;
    off_q   <= off_d;
    first_q <= first_d;
    head_q  <= head_d;
    cyl_q   <= cyl_d;
    out_q   <= out_d;
  end

  assign run_o.valid         = vld_q;
  assign run_o.cylinder      = out_q.cylinder;
  assign run_o.head          = out_q.head;
  assign run_o.first_sector  = out_q.first_sector;
  assign run_o.run_sectors   = out_q.run_sectors;
  assign run_o.buffer_offset = out_q.buffer_offset;
  assign run_o.run_bytes     = out_q.run_bytes;
  assign run_o.dir_out       = out_q.dir_out;
  assign run_o.last_run      = out_q.last_run;

endmodule

/* rtl/lcts_checker.sv */
// ----------------------------------------------------------------------------
// lcts_checker
// port-level checks for the lba to chs splitter, bound to the top level
// ----------------------------------------------------------------------------
module lcts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [6:0]  req_total_i,
  input logic        run_valid_i,
  input logic        run_ready_i,
  input logic [6:0]  run_sectors_i,
  input logic [18:0] run_bytes_i,
  input logic [17:0] run_offset_i,
  input logic        run_last_i
);

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_i && !run_ready_i |=> run_valid_i && $stable(run_sectors_i)
      && $stable(run_bytes_i) && $stable(run_offset_i) && $stable(run_last_i))
    else $error("run word changed while stalled");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_i |-> run_sectors_i != 7'd0 && run_sectors_i <= 7'd64)
    else $error("run length out of range");

  // a non-final word means the request is still being split
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_i && run_ready_i && !run_last_i |-> !req_ready_i)
    else $error("new request taken before last run");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_total_i != 7'd0 |=> !req_ready_i)
    else $error("ready stayed high after a nonempty request");

endmodule

bind lba_to_chs_track_splitter_unit lcts_checker u_lcts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_total_i   (req_i.sector_total),
  .run_valid_i   (run_o.valid),
  .run_ready_i   (run_o.ready),
  .run_sectors_i (run_o.run_sectors),
  .run_bytes_i   (run_o.run_bytes),
  .run_offset_i  (run_o.buffer_offset),
  .run_last_i    (run_o.last_run)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// lba to chs splitter check: requests go in through a queued driver, and
// every run word is compared against runs computed in the bench from the
// same geometry, under light, heavy and no idling and one long output stall
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcts_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_NONE = 2'd3;  // no register behind it
  localparam int unsigned IDLE_LIGHT   = 13;
  localparam int unsigned IDLE_HEAVY   = 78;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned MAX_PRINTS   = 100;

  typedef struct {
    logic [AddrW-1:0]  start;
    logic [CountW-1:0] total;
    logic              dir;
  } request_t;

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [SbW-1:0]     cfg_data;

  lcts_req_if req ();
  lcts_run_if run ();

  lba_to_chs_track_splitter_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .run_o      (run),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // geometry as the block should hold it
  logic [GeoW-1:0] geo_spt    = SptReset;
  logic [GeoW-1:0] geo_heads  = HeadsReset;
  logic [SbW-1:0]  geo_sbytes = SbReset;

  request_t      request_backlog[$];
  run_t          pending_runs[$];
  request_t      next_req;
  int            requests_open = 0;
  bit            req_taken = 1'b0;
  int unsigned   mismatches = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  bit            rx_hold = 1'b0;
  int            phase_no = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // split one request into track-bounded runs, appended to pending_runs
  function automatic void split_into_runs(input logic [AddrW-1:0] start,
                                          input logic [CountW-1:0] total,
                                          input logic dir);
    int unsigned addr, left, spt, heads, done, track, first, room, run_len;
    run_t r;
    addr  = start;
    left  = total;
    spt   = (geo_spt == 0) ? 1 : geo_spt;
    heads = (geo_heads == 0) ? 1 : geo_heads;
    done  = 0;
    if (left > MAX_RUN_SECTORS) left = MAX_RUN_SECTORS;
    while (left > 0) begin
      track   = addr / spt;
      first   = addr % spt;
      room    = spt - first;
      run_len = (left > room) ? room : left;
      left   -= run_len;
      r.cylinder      = 16'(track / heads);
      r.head          = 8'(track % heads);
      r.first_sector  = 8'(first);
      r.run_sectors   = 7'(run_len);
      r.buffer_offset = 18'(done * geo_sbytes);
      r.run_bytes     = 19'(run_len * geo_sbytes);
      r.dir_out       = dir;
      r.last_run      = (left == 0);
      pending_runs.push_back(r);
      done += run_len;
      addr  = (addr + run_len) & 16'hFFFF;
    end
  endfunction

  task automatic check_run_word();
    run_t want;
    if (pending_runs.size() == 0) begin
      report_mismatch("run word with nothing pending, cylinder", run.cylinder, 0);
    end else begin
      want = pending_runs.pop_front();
      if (run.cylinder !== want.cylinder)
        report_mismatch("cylinder", run.cylinder, want.cylinder);
      if (run.head !== want.head)
        report_mismatch("head", run.head, want.head);
      if (run.first_sector !== want.first_sector)
        report_mismatch("first_sector", run.first_sector, want.first_sector);
      if (run.run_sectors !== want.run_sectors)
        report_mismatch("run_sectors", run.run_sectors, want.run_sectors);
      if (run.buffer_offset !== want.buffer_offset)
        report_mismatch("buffer_offset", run.buffer_offset, want.buffer_offset);
      if (run.run_bytes !== want.run_bytes)
        report_mismatch("run_bytes", run.run_bytes, want.run_bytes);
      if (run.dir_out !== want.dir_out)
        report_mismatch("dir_out", run.dir_out, want.dir_out);
      if (run.last_run !== want.last_run)
        report_mismatch("last_run", run.last_run, want.last_run);
    end
  endtask

  // register writes, request acceptance and run checking, all at the rising edge
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_spt    = SptReset;
      geo_heads  = HeadsReset;
      geo_sbytes = SbReset;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SPT:    geo_spt    = cfg_data[GeoW-1:0];
          CFG_HEADS:  geo_heads  = cfg_data[GeoW-1:0];
          CFG_SBYTES: geo_sbytes = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        split_into_runs(req.start_sector, req.sector_total, req.write_dir);
        requests_open--;
        req_taken = 1'b1;
      end
      if (run.valid && run.ready) check_run_word();
    end
  end

  // request driver: holds a word until taken, then maybe idles
  always @(negedge clk) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      req_taken = 1'b0;
      if (request_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_req = request_backlog.pop_front();
        req.valid        <= 1'b1;
        req.start_sector <= next_req.start;
        req.sector_total <= next_req.total;
        req.write_dir    <= next_req.dir;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_ni) run.ready <= 1'b0;
    else run.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // long output stall while requests keep coming
  initial begin
    wait (phase_no == 6);
    repeat (30) @(posedge clk);
    rx_hold = 1'b1;
    repeat (500) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SbW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned spt, input int unsigned heads,
                              input int unsigned sbytes);
    write_reg(CFG_SPT, 13'(spt));
    write_reg(CFG_HEADS, 13'(heads));
    write_reg(CFG_SBYTES, 13'(sbytes));
  endtask

  task automatic begin_phase(input int num, input int unsigned tx, input int unsigned rx);
    @(posedge clk);
    phase_no    = num;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  task automatic queue_req(input int unsigned start, input int unsigned total,
                           input bit dir);
    request_t q;
    q.start = 16'(start);
    q.total = 7'(total);
    q.dir   = dir;
    request_backlog.push_back(q);
    requests_open++;
  endtask

  function automatic request_t random_request();
    request_t q;
    int unsigned pick, spt, base;
    spt  = (geo_spt == 0) ? 1 : geo_spt;
    pick = $urandom_range(99);
    if (pick < 45) begin
      q.start = 16'($urandom_range(65535));
    end else if (pick < 75) begin
      // just short of a track boundary
      base    = $urandom_range(65535) / spt * spt;
      q.start = 16'(base + spt - 1 - $urandom_range((spt > 2) ? 2 : spt - 1));
    end else if (pick < 88) begin
      q.start = 16'(65535 - $urandom_range(80));
    end else begin
      q.start = 16'($urandom_range(300));
    end
    pick = $urandom_range(99);
    if (pick < 40)      q.total = 7'($urandom_range(8, 1));
    else if (pick < 85) q.total = 7'($urandom_range(64, 1));
    else if (pick < 91) q.total = '0;
    else                q.total = 7'($urandom_range(127, 65));
    q.dir = 1'($urandom_range(1));
    return q;
  endfunction

  task automatic queue_random(input int n);
    repeat (n) begin
      request_backlog.push_back(random_request());
      requests_open++;
    end
  endtask

  // a zero-count request leaves nothing pending, so settle before any write
  task automatic wait_drained();
    while (requests_open != 0 || pending_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_SPT;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.start_sector = '0;
    req.sector_total = '0;
    req.write_dir    = 1'b0;
    run.ready        = 1'b0;
    repeat (5) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // reset geometry: 18 sectors, 2 heads, 512 bytes
    begin_phase(0, IDLE_LIGHT, IDLE_HEAVY);
    queue_req(0, 1, 0);
    queue_req(65535, 64, 1);  // address wraps past 65535
    queue_req(17, 2, 0);      // crosses a track
    queue_req(0, 0, 1);       // zero count
    queue_req(100, 127, 0);   // clamped count
    queue_req(36, 65, 1);
    queue_req(18, 18, 1);     // whole track on head one
    queue_req(65520, 40, 0);
    queue_req(1, 64, 0);
    queue_req(35, 3, 1);
    queue_random(20);
    wait_drained();

    set_geometry(1, 1, 128);
    begin_phase(1, IDLE_LIGHT, IDLE_HEAVY);
    queue_req(65535, 64, 1);
    queue_req(0, 127, 0);
    queue_req(40000, 0, 1);
    queue_random(25);
    wait_drained();

    set_geometry(255, 255, 4096);
    begin_phase(2, IDLE_LIGHT, IDLE_HEAVY);
    queue_req(65535, 64, 0);
    queue_req(65279, 64, 1);
    queue_req(254, 2, 0);
    queue_random(25);
    wait_drained();

    // zero geometry counts as one, oversized sector wraps the offset
    set_geometry(0, 0, 8191);
    begin_phase(3, IDLE_HEAVY, IDLE_LIGHT);
    queue_req(65500, 64, 1);
    queue_req(12345, 65, 0);
    queue_req(0, 1, 1);
    queue_random(25);
    wait_drained();

    write_reg(CFG_NONE, 13'h1FFF);   // ignored
    write_reg(CFG_SPT, 13'h1F12);    // upper data bits dropped
    write_reg(CFG_HEADS, 13'd16);
    write_reg(CFG_SBYTES, 13'd0);
    begin_phase(4, IDLE_HEAVY, IDLE_LIGHT);
    queue_random(25);
    wait_drained();

    set_geometry($urandom_range(255, 1), $urandom_range(255, 1),
                 $urandom_range(4096, 128));
    begin_phase(5, IDLE_HEAVY, IDLE_LIGHT);
    queue_random(30);
    wait_drained();

    set_geometry($urandom_range(255, 1), $urandom_range(255, 1),
                 $urandom_range(4096, 128));
    begin_phase(6, 0, 0);
    queue_random(40);
    wait_drained();

    set_geometry($urandom_range(9, 2), $urandom_range(255, 1),
                 $urandom_range(4096, 128));
    begin_phase(7, 0, 0);
    queue_random(20);
    wait_drained();

    if (pending_runs.size() != 0)
      report_mismatch("runs never delivered", pending_runs.size(), 0);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lcts_pkg.sv
rtl/lcts_req_if.sv
rtl/lcts_run_if.sv
rtl/lcts_div.sv
rtl/lba_to_chs_track_splitter_unit.sv
rtl/lcts_checker.sv
tb/sv/testbench.sv
